FILE: sv/t9_word_start_matcher_top_assert.svh
// ----------------------------------------------------------------------------
// T9 word start matcher assertion macros
// Shorthand for the concurrent checks of the matcher; each expects clk and
// rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef T9_WORD_START_MATCHER_TOP_ASSERT_SVH
`define T9_WORD_START_MATCHER_TOP_ASSERT_SVH

// A property that holds at every clock edge outside reset.
`define T9WSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that, once seen, forces a consequence at the next edge.
`define T9WSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/t9wsm_pkg.sv
// ----------------------------------------------------------------------------
// T9 word start matcher package
// Widths, register indexes, queue sizing, the keypad table and the queue
// entry type shared by the matcher modules.
// ----------------------------------------------------------------------------
package t9wsm_pkg;

    localparam int CHAR_W     = 16;
    localparam int SYM_W      = 4;
    localparam int POS_W      = 8;
    localparam int PAT_SYM_W  = 48;
    localparam int PAT_LEN_W  = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [PAT_LEN_W-1:0] MAX_PATTERN  = 4'd12;
    localparam logic [POS_W-1:0]     MAX_NAME_LEN = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SYMBOLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH  = 2'd1;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 16'h002B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 16'h0020;

    // A pattern index of zero means the search waits for a space.
    localparam logic [PAT_LEN_W-1:0] IDX_WAIT  = 4'd0;
    localparam logic [PAT_LEN_W-1:0] IDX_FIRST = 4'd1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Keypad symbols for the 8-bit code page, 32 codes per row, the lowest
    // code of a row in the most significant nibble. 'A' stands for '*'.
    localparam logic [127:0] SYM_ROWS [8] = '{
        128'h11111111111111111111111111111111,
        128'h10001AA0AAA0000A012345678900AAA0,
        128'h0222333444555666777788899991A110,
        128'h122233344455566677778889999111A1,
        128'h11111111111111111111111111111111,
        128'h11111111311111111111111131111111,
        128'h22223333444455566677778888899999,
        128'h22223333444455566677778888899999
    };

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_plus;
        logic             is_space;
        logic             last;
    } qentry_t;

    // Folds Cyrillic to the code page and looks the byte up in the table.
    function automatic logic [SYM_W-1:0] char_symbol(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] folded;
        logic [7:0]        code;
        folded = c;
        if (c >= 16'h0410 && c < 16'h0450) begin
            folded = c - 16'h0350;
        end
        if (c == 16'h0401) begin
            folded = 16'h00A8;
        end
        if (c == 16'h0451) begin
            folded = 16'h00B8;
        end
        code = folded[7:0];
        return SYM_ROWS[code[7:5]][{~code[4:0], 2'b00} +: SYM_W];
    endfunction

endpackage

FILE: sv/t9wsm_if.sv
// ----------------------------------------------------------------------------
// T9 word start matcher channel interfaces
// Character, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface t9wsm_char_if;
    logic                            valid;
    logic                            ready;
    logic [t9wsm_pkg::CHAR_W-1:0]    name_char;
    logic                            last_char;

    modport source (output valid, output name_char, output last_char, input ready);
    modport sink   (input valid, input name_char, input last_char, output ready);
endinterface

interface t9wsm_res_if;
    logic                            valid;
    logic                            ready;
    logic                            matched;
    logic [t9wsm_pkg::POS_W-1:0]     first_position;
    logic [t9wsm_pkg::POS_W-1:0]     end_position;

    modport source (output valid, output matched, output first_position,
                    output end_position, input ready);
    modport sink   (input valid, input matched, input first_position,
                    input end_position, output ready);
endinterface

interface t9wsm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [t9wsm_pkg::CFG_IDX_W-1:0] index;
    logic [t9wsm_pkg::PAT_SYM_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/t9wsm_front.sv
// ----------------------------------------------------------------------------
// T9 word start matcher front end
// Accepts characters and turns each into a keypad symbol with flags.
// ----------------------------------------------------------------------------
module t9wsm_front (
    t9wsm_char_if.sink          name_in,
    output t9wsm_pkg::qentry_t  q_entry,
    output logic                q_push,
    input  logic                q_ready
);
    import t9wsm_pkg::*;

    assign name_in.ready = q_ready;
    assign q_push        = name_in.valid && q_ready;

    always_comb
    begin
        q_entry.symbol   = char_symbol(name_in.name_char);
        q_entry.is_plus  = (name_in.name_char == CHAR_PLUS);
        q_entry.is_space = (name_in.name_char == CHAR_SPACE);
        q_entry.last     = name_in.last_char;
    end

endmodule

FILE: sv/t9wsm_fifo.sv
// ----------------------------------------------------------------------------
// T9 word start matcher queue
// Short register queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module t9wsm_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  t9wsm_pkg::qentry_t  in_entry,
    input  logic                push,
    output logic                in_ready,
    output t9wsm_pkg::qentry_t  out_entry,
    output logic                out_valid,
    input  logic                pop
);
    import t9wsm_pkg::*;

    `include "t9_word_start_matcher_top_assert.svh"

    qentry_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic [Q_CNT_W-1:0]   cnt_next;
    logic                 do_pop;

    assign in_ready  = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_entry = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !do_pop) begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end else if (do_pop && !push) begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    `T9WSM_ASSERT(a_cnt_bound, cnt_reg <= Q_CNT_W'(Q_DEPTH), "queue count above depth")
    `T9WSM_ASSERT(a_no_overflow, !(push && !in_ready), "push into a full queue")
    `T9WSM_ASSERT_NEXT(a_cnt_grow, push && !do_pop, cnt_reg == $past(cnt_reg) + Q_CNT_W'(1), "queue count did not grow on push")

endmodule

FILE: sv/t9wsm_back.sv
// ----------------------------------------------------------------------------
// T9 word start matcher back end
// Holds the pattern registers, runs the word start match over the queued
// symbols and keeps the result register.
// ----------------------------------------------------------------------------
module t9wsm_back (
    input  logic                clk,
    input  logic                rst_n,
    t9wsm_cfg_if.sink           cfg,
    input  t9wsm_pkg::qentry_t  q_entry,
    input  logic                q_valid,
    output logic                q_pop,
    t9wsm_res_if.source         result_out
);
    import t9wsm_pkg::*;

    `include "t9_word_start_matcher_top_assert.svh"

    logic [PAT_SYM_W-1:0] pat_sym_reg;
    logic [PAT_LEN_W-1:0] pat_len_reg;

    logic [PAT_LEN_W-1:0] idx_reg;
    logic [PAT_LEN_W-1:0] idx_next;
    logic [POS_W-1:0]     run_start_reg;
    logic [POS_W-1:0]     run_start_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic                 found_reg;
    logic                 found_next;
    logic [POS_W-1:0]     found_end_reg;
    logic [POS_W-1:0]     found_end_next;

    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic                 res_matched_reg;
    logic                 res_matched_next;
    logic [POS_W-1:0]     res_first_reg;
    logic [POS_W-1:0]     res_first_next;
    logic [POS_W-1:0]     res_end_reg;
    logic [POS_W-1:0]     res_end_next;

    logic [PAT_LEN_W-1:0] len_eff;
    logic [PAT_LEN_W-1:0] want_idx;
    logic [SYM_W-1:0]     want;
    logic                 take;
    logic [POS_W-1:0]     pos_new;

    assign cfg.ready = 1'b1;

    assign result_out.valid          = res_valid_reg;
    assign result_out.matched        = res_matched_reg;
    assign result_out.first_position = res_first_reg;
    assign result_out.end_position   = res_end_reg;

    // The final character waits only while an untaken result occupies the
    // output register; other characters never wait.
    assign q_pop = q_valid && (!q_entry.last || !res_valid_reg || result_out.ready);

    assign len_eff  = (pat_len_reg > MAX_PATTERN) ? MAX_PATTERN : pat_len_reg;
    assign want_idx = idx_reg - PAT_LEN_W'(1);
    assign want     = (want_idx < MAX_PATTERN) ?
                      pat_sym_reg[{want_idx, 2'b00} +: SYM_W] : '0;
    assign take     = (pos_reg != MAX_NAME_LEN);
    assign pos_new  = take ? pos_reg + POS_W'(1) : pos_reg;

    always_comb
    begin
        idx_next         = idx_reg;
        run_start_next   = run_start_reg;
        pos_next         = pos_reg;
        found_next       = found_reg;
        found_end_next   = found_end_reg;
        res_valid_next   = res_valid_reg && !result_out.ready;
        res_matched_next = res_matched_reg;
        res_first_next   = res_first_reg;
        res_end_next     = res_end_reg;

        if (q_pop) begin
            pos_next = pos_new;
            if (take && !found_reg && len_eff != '0) begin
                priority if (pos_new == POS_W'(1) && q_entry.is_plus) begin
                    idx_next = idx_reg;
                end else if (idx_reg == IDX_WAIT) begin
                    if (q_entry.is_space) begin
                        idx_next = IDX_FIRST;
                    end
                end else if (q_entry.symbol == want) begin
                    if (run_start_reg == '0) begin
                        run_start_next = pos_new;
                    end
                    if (idx_reg >= len_eff) begin
                        found_next     = 1'b1;
                        found_end_next = pos_new;
                    end else begin
                        idx_next = idx_reg + PAT_LEN_W'(1);
                    end
                end else begin
                    run_start_next = '0;
                    idx_next       = IDX_WAIT;
                end
            end

            if (q_entry.last) begin
                res_valid_next = 1'b1;
                if (len_eff == '0) begin
                    res_matched_next = 1'b1;
                    res_first_next   = '0;
                    res_end_next     = '0;
                end else if (found_next) begin
                    res_matched_next = 1'b1;
                    res_first_next   = run_start_next;
                    res_end_next     = found_end_next;
                end else begin
                    res_matched_next = 1'b0;
                    res_first_next   = '0;
                    res_end_next     = '0;
                end
                idx_next       = IDX_FIRST;
                run_start_next = '0;
                pos_next       = '0;
                found_next     = 1'b0;
                found_end_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pat_sym_reg   <= '0;
            pat_len_reg   <= '0;
            idx_reg       <= IDX_FIRST;
            run_start_reg <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            found_end_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (cfg.valid) begin
                if (cfg.index == CFG_PATTERN_SYMBOLS) begin
                    pat_sym_reg <= cfg.data;
                end else if (cfg.index == CFG_PATTERN_LENGTH) begin
                    pat_len_reg <= cfg.data[PAT_LEN_W-1:0];
                end
            end
            idx_reg       <= idx_next;
            run_start_reg <= run_start_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            found_end_reg <= found_end_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_matched_reg <= res_matched_next;
        res_first_reg   <= res_first_next;
        res_end_reg     <= res_end_next;
    end

    `T9WSM_ASSERT(a_idx_bound, idx_reg <= MAX_PATTERN, "pattern index beyond pattern")
    `T9WSM_ASSERT(a_found_run, !found_reg || (run_start_reg != '0 && found_end_reg >= run_start_reg), "found without a run")
    `T9WSM_ASSERT_NEXT(a_name_clear, q_pop && q_entry.last, pos_reg == '0 && !found_reg && res_valid_reg, "name state not cleared after result")

endmodule

FILE: sv/t9_word_start_matcher_top.sv
// ----------------------------------------------------------------------------
// T9 word start matcher top level
// Keypad pattern search over the characters of one name at word starts.
// ----------------------------------------------------------------------------
// Usage: load the pattern over cfg (index 0 the packed symbols, index 1 the
// length) while no name is in flight; cfg is always ready. Then stream the
// UTF-16 characters of a name over name_in, one beat per character, with
// last_char set on the final beat. Exactly one beat appears on result_out per
// name: matched, and the first and end positions of the matched run.
// Throughput is one character per cycle while no final character waits on a
// held result: the front classifies a character in the cycle it is accepted,
// and the back handles one queued character per cycle. A final character
// passes through the queue and then the result register, after any characters
// still queued ahead of it. When result_out stalls, the held result stays in
// the output register and the back keeps consuming characters of the next
// name; only the next final character waits. The four-entry queue then fills,
// and name_in.ready drops once it is full. Reset clears the queue, the match
// state, the valid flag of the result register and both pattern registers.
// ----------------------------------------------------------------------------
module t9_word_start_matcher_top (
    input  logic         clk,
    input  logic         rst_n,
    t9wsm_cfg_if.sink    cfg,
    t9wsm_char_if.sink   name_in,
    t9wsm_res_if.source  result_out
);
    import t9wsm_pkg::*;

    qentry_t push_entry;
    logic    push;
    logic    push_ready;
    qentry_t pop_entry;
    logic    pop_valid;
    logic    pop;

    // Front end: accept a character and classify it into a keypad symbol.
    t9wsm_front u_front (
        .name_in (name_in),
        .q_entry (push_entry),
        .q_push  (push),
        .q_ready (push_ready)
    );

    // Queue that lets the front keep accepting while the back waits.
    t9wsm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_entry  (push_entry),
        .push      (push),
        .in_ready  (push_ready),
        .out_entry (pop_entry),
        .out_valid (pop_valid),
        .pop       (pop)
    );

    // Back end: the match state machine and the result register.
    t9wsm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_entry    (pop_entry),
        .q_valid    (pop_valid),
        .q_pop      (pop),
        .result_out (result_out)
    );

endmodule
